### rtl/core/ctsw_pkg.sv
// ----------------------------------------------------------------------------
// ctsw_pkg
// Shared widths and register indexes of the chiplet-aware tile swizzle unit.
// ----------------------------------------------------------------------------
package ctsw_pkg;

   // datapath width of the divider chains, all but the column chain
   localparam int DIV_W      = 32;
   localparam int TILE_W     = 16;
   localparam int GROUP_W    = 8;
   localparam int DIE_W      = 5;
   localparam int CHUNK_W    = 8;
   localparam int BLOCK_W    = DIE_W + CHUNK_W;
   localparam int PER_GRP_W  = GROUP_W + TILE_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_ROWS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_COLS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIE_COUNT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_LENGTH = 3'd4;

endpackage

### rtl/core/ctsw_div_cell.sv
// ----------------------------------------------------------------------------
// ctsw_div_cell
// One restoring division step: shifts one dividend bit into the partial
// remainder, subtracts the divisor when it fits and records the quotient bit.
// ----------------------------------------------------------------------------
module ctsw_div_cell #(
   parameter int DW = 32,
   parameter int VW = 8,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  logic [VW-1:0] in_rem,
   input  logic [DW-1:0] in_num,
   input  logic [VW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [VW-1:0] out_rem,
   output logic [DW-1:0] out_num,
   output logic [VW-1:0] out_den,
   output logic [SW-1:0] out_side
);

   logic          valid_ff;
   logic [VW-1:0] rem_ff, rem_in;
   logic [DW-1:0] num_ff, num_in;
   logic [VW-1:0] den_ff;
   logic [SW-1:0] side_ff;
   logic [VW:0]   shifted;
   logic [VW:0]   diff;
   logic          take;

   // trial subtract
   always_comb begin
      shifted = {in_rem, in_num[DW-1]};
      diff    = shifted - {1'b0, in_den};
      take    = shifted >= {1'b0, in_den};
      rem_in  = take ? diff[VW-1:0] : shifted[VW-1:0];
      num_in  = {in_num[DW-2:0], take};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         num_ff  <= num_in;
         den_ff  <= in_den;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_side  = side_ff;

endmodule

### rtl/core/ctsw_div.sv
// ----------------------------------------------------------------------------
// ctsw_div
// Pipelined divider: a chain of DW division cells, one quotient bit per cell,
// with side data carried along with each word.
// ----------------------------------------------------------------------------
module ctsw_div #(
   parameter int DW = 32,
   parameter int VW = 8,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  logic [DW-1:0] in_num,
   input  logic [VW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [DW-1:0] out_quo,
   output logic [VW-1:0] out_rem,
   output logic [SW-1:0] out_side
);

   logic          valid_w [0:DW];
   logic [VW-1:0] rem_w   [0:DW];
   logic [DW-1:0] num_w   [0:DW];
   logic [VW-1:0] den_w   [0:DW];
   logic [SW-1:0] side_w  [0:DW];

   // chain head
   assign valid_w[0] = in_valid;
   assign rem_w[0]   = '0;
   assign num_w[0]   = in_num;
   assign den_w[0]   = in_den;
   assign side_w[0]  = in_side;

   // cell chain
   for (genvar i = 0; i < DW; i++) begin : g_cell
      ctsw_div_cell #(.DW(DW), .VW(VW), .SW(SW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (valid_w[i]),
         .in_rem    (rem_w[i]),
         .in_num    (num_w[i]),
         .in_den    (den_w[i]),
         .in_side   (side_w[i]),
         .out_valid (valid_w[i+1]),
         .out_rem   (rem_w[i+1]),
         .out_num   (num_w[i+1]),
         .out_den   (den_w[i+1]),
         .out_side  (side_w[i+1])
      );
   end

   assign out_valid = valid_w[DW];
   assign out_quo   = num_w[DW];
   assign out_rem   = rem_w[DW];
   assign out_side  = side_w[DW];

endmodule

### rtl/core/chiplet_aware_tile_swizzle_unit.sv
// ----------------------------------------------------------------------------
// chiplet_aware_tile_swizzle_unit
// Maps a linear workgroup id to a tile row and column: chiplet chunk remap
// followed by a grouped super-tile swizzle clipped at the bottom edge.
// ----------------------------------------------------------------------------
// The unit takes one word per cycle unless the result side stalls and returns
// one result word per id, in order, through five chains of division cells
// (32, 32, 32, 32 and 24 cells, one quotient bit per cell) and six registers:
// input, two multiply stages, remap add, clip, output. A stall on the result
// side freezes the whole chain, so ready follows the output register. Ids not
// below tile_rows * tile_cols return zeros with out_of_range set. Write
// registers only while no word is in flight; the block does not enforce it.
module chiplet_aware_tile_swizzle_unit
   import ctsw_pkg::*;
#(
   parameter int ID_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [ID_BITS-1:0]    req_work_id,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [TILE_W-1:0]     rsp_tile_row,
   output logic [TILE_W-1:0]     rsp_tile_col,
   output logic                  rsp_out_of_range,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // configuration registers
   logic [TILE_W-1:0]  rows_ff, cols_ff;
   logic [GROUP_W-1:0] gh_ff;
   logic [DIE_W-1:0]   dies_ff;
   logic [CHUNK_W-1:0] chunk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= TILE_W'(1);
         cols_ff  <= TILE_W'(1);
         gh_ff    <= GROUP_W'(1);
         dies_ff  <= DIE_W'(1);
         chunk_ff <= CHUNK_W'(1);
      end else if (csr_write) begin
         case (csr_index)
            CSR_TILE_ROWS:    rows_ff  <= csr_data;
            CSR_TILE_COLS:    cols_ff  <= csr_data;
            CSR_GROUP_HEIGHT: gh_ff    <= csr_data[GROUP_W-1:0];
            CSR_DIE_COUNT:    dies_ff  <= csr_data[DIE_W-1:0];
            CSR_CHUNK_LENGTH: chunk_ff <= csr_data[CHUNK_W-1:0];
            default: ;
         endcase
      end
   end

   // zero group height, die count and chunk length behave as one
   logic [GROUP_W-1:0] gh_eff;
   logic [DIE_W-1:0]   dies_eff;
   logic [CHUNK_W-1:0] chunk_eff;

   assign gh_eff    = (gh_ff == '0)    ? GROUP_W'(1) : gh_ff;
   assign dies_eff  = (dies_ff == '0)  ? DIE_W'(1)   : dies_ff;
   assign chunk_eff = (chunk_ff == '0) ? CHUNK_W'(1) : chunk_ff;

   // products derived from the registers
   logic [DIV_W-1:0]     total_ff;
   logic [PER_GRP_W-1:0] per_group_ff;
   logic [BLOCK_W-1:0]   block_ff;

   always_ff @(posedge clock) begin
      total_ff     <= DIV_W'(rows_ff) * DIV_W'(cols_ff);
      per_group_ff <= PER_GRP_W'(gh_eff) * PER_GRP_W'(cols_ff);
      block_ff     <= BLOCK_W'(dies_eff) * BLOCK_W'(chunk_eff);
   end

   logic advance;
   logic rsp_valid_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // input register
   logic             s0_valid_ff;
   logic [DIV_W-1:0] s0_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_id_ff <= DIV_W'(req_work_id);
      end
   end

   logic s0_oor;
   assign s0_oor = s0_id_ff >= total_ff;

   // remap limit: total modulo block
   logic               d3_valid;
   logic [DIV_W-1:0]   d3_quo;
   logic [BLOCK_W-1:0] d3_rem;
   logic [DIV_W:0]     d3_side;

   ctsw_div #(.DW(DIV_W), .VW(BLOCK_W), .SW(DIV_W + 1)) u_div_limit (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s0_valid_ff),
      .in_num    (total_ff),
      .in_den    (block_ff),
      .in_side   ({s0_oor, s0_id_ff}),
      .out_valid (d3_valid),
      .out_quo   (d3_quo),
      .out_rem   (d3_rem),
      .out_side  (d3_side)
   );

   logic             d3_oor;
   logic [DIV_W-1:0] d3_id;
   logic             d3_remap;

   assign d3_oor   = d3_side[DIV_W];
   assign d3_id    = d3_side[DIV_W-1:0];
   assign d3_remap = (d3_quo != '0) && (d3_id < (total_ff - DIV_W'(d3_rem)));

   // die index and id within die
   logic             d1_valid;
   logic [DIV_W-1:0] d1_quo;
   logic [DIE_W-1:0] d1_rem;
   logic [DIV_W+1:0] d1_side;

   ctsw_div #(.DW(DIV_W), .VW(DIE_W), .SW(DIV_W + 2)) u_div_die (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (d3_valid),
      .in_num    (d3_id),
      .in_den    (dies_eff),
      .in_side   ({d3_oor, d3_remap, d3_id}),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_rem   (d1_rem),
      .out_side  (d1_side)
   );

   // chunk index and offset within chunk
   localparam int D2_SW = DIV_W + 2 + DIE_W;

   logic               d2_valid;
   logic [DIV_W-1:0]   d2_quo;
   logic [CHUNK_W-1:0] d2_rem;
   logic [D2_SW-1:0]   d2_side;

   ctsw_div #(.DW(DIV_W), .VW(CHUNK_W), .SW(D2_SW)) u_div_chunk (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (d1_valid),
      .in_num    (d1_quo),
      .in_den    (chunk_eff),
      .in_side   ({d1_side, d1_rem}),
      .out_valid (d2_valid),
      .out_quo   (d2_quo),
      .out_rem   (d2_rem),
      .out_side  (d2_side)
   );

   // chunk base and die offset products
   logic               m1_valid_ff;
   logic [DIV_W-1:0]   m1_base_ff;
   logic [BLOCK_W-1:0] m1_die_off_ff;
   logic [CHUNK_W-1:0] m1_off_ff;
   logic               m1_remap_ff;
   logic               m1_oor_ff;
   logic [DIV_W-1:0]   m1_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (advance) begin
         m1_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m1_base_ff    <= d2_quo * DIV_W'(block_ff);
         m1_die_off_ff <= BLOCK_W'(d2_side[DIE_W-1:0]) * BLOCK_W'(chunk_eff);
         m1_off_ff     <= d2_rem;
         m1_oor_ff     <= d2_side[D2_SW-1];
         m1_remap_ff   <= d2_side[D2_SW-2];
         m1_id_ff      <= d2_side[DIE_W +: DIV_W];
      end
   end

   // remapped id
   logic             m2_valid_ff;
   logic [DIV_W-1:0] m2_id_ff;
   logic             m2_oor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (advance) begin
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m2_id_ff  <= m1_remap_ff
                      ? m1_base_ff + DIV_W'(m1_die_off_ff) + DIV_W'(m1_off_ff)
                      : m1_id_ff;
         m2_oor_ff <= m1_oor_ff;
      end
   end

   // super-tile group and position inside it
   logic                 d4_valid;
   logic [DIV_W-1:0]     d4_quo;
   logic [PER_GRP_W-1:0] d4_rem;
   logic                 d4_oor;

   ctsw_div #(.DW(DIV_W), .VW(PER_GRP_W), .SW(1)) u_div_group (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (m2_valid_ff),
      .in_num    (m2_id_ff),
      .in_den    (per_group_ff),
      .in_side   (m2_oor_ff),
      .out_valid (d4_valid),
      .out_quo   (d4_quo),
      .out_rem   (d4_rem),
      .out_side  (d4_oor)
   );

   // first row of the group
   logic                 f1_valid_ff;
   logic [DIV_W-1:0]     f1_first_ff;
   logic [PER_GRP_W-1:0] f1_local_ff;
   logic                 f1_oor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (advance) begin
         f1_valid_ff <= d4_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_first_ff <= d4_quo * DIV_W'(gh_eff);
         f1_local_ff <= d4_rem;
         f1_oor_ff   <= d4_oor;
      end
   end

   // group height clipped at the bottom edge
   logic [TILE_W:0] f1_left;
   assign f1_left = {1'b0, rows_ff} - {1'b0, f1_first_ff[TILE_W-1:0]};

   logic                 f2_valid_ff;
   logic [TILE_W-1:0]    f2_first_ff;
   logic [PER_GRP_W-1:0] f2_local_ff;
   logic [GROUP_W-1:0]   f2_rows_here_ff;
   logic                 f2_oor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_valid_ff <= 1'b0;
      end else if (advance) begin
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f2_first_ff     <= f1_first_ff[TILE_W-1:0];
         f2_local_ff     <= f1_local_ff;
         f2_rows_here_ff <= ((TILE_W + 1)'(gh_eff) < f1_left)
                            ? gh_eff : f1_left[GROUP_W-1:0];
         f2_oor_ff       <= f1_oor_ff;
      end
   end

   // column and row inside the group
   logic                 d5_valid;
   logic [PER_GRP_W-1:0] d5_quo;
   logic [GROUP_W-1:0]   d5_rem;
   logic [TILE_W:0]      d5_side;

   ctsw_div #(.DW(PER_GRP_W), .VW(GROUP_W), .SW(TILE_W + 1)) u_div_col (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (f2_valid_ff),
      .in_num    (f2_local_ff),
      .in_den    (f2_rows_here_ff),
      .in_side   ({f2_oor_ff, f2_first_ff}),
      .out_valid (d5_valid),
      .out_quo   (d5_quo),
      .out_rem   (d5_rem),
      .out_side  (d5_side)
   );

   // output register
   logic [TILE_W-1:0] rsp_row_ff, rsp_col_ff;
   logic              rsp_oor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= d5_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_oor_ff <= d5_side[TILE_W];
         rsp_row_ff <= d5_side[TILE_W]
                       ? '0 : d5_side[TILE_W-1:0] + TILE_W'(d5_rem);
         rsp_col_ff <= d5_side[TILE_W] ? '0 : d5_quo[TILE_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tile_row     = rsp_row_ff;
   assign rsp_tile_col     = rsp_col_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

### tb/sv/chiplet_aware_tile_swizzle_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chiplet_aware_tile_swizzle_checker
// Watches the id and tile channels of the swizzle unit, predicts the tile
// coordinates of every accepted id from its own register copy and compares
// each result word field by field, in order.
// ----------------------------------------------------------------------------
module chiplet_aware_tile_swizzle_checker
   import ctsw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [31:0]           req_work_id,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [TILE_W-1:0]     rsp_tile_row,
   input  logic [TILE_W-1:0]     rsp_tile_col,
   input  logic                  rsp_out_of_range,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    pending_count
);

   typedef struct packed {
      logic [TILE_W-1:0] row;
      logic [TILE_W-1:0] col;
      logic              oor;
   } tile_type;

   tile_type tile_queue[$];

   logic [15:0] rows_q, cols_q;
   logic [7:0]  group_q, chunk_q;
   logic [4:0]  dies_q;

   // tile coordinates of one id under the current register copy
   function automatic tile_type swizzle_tile(logic [31:0] id);
      longint unsigned total, dies, chunk, blk, lim, r, gh, per_grp;
      longint unsigned first, left, rows_here, loc;
      tile_type t;
      total = longint'(rows_q) * longint'(cols_q);
      t = '0;
      if (id >= total) begin
         t.oor = 1'b1;
         return t;
      end
      dies  = (dies_q == 0) ? 1 : dies_q;
      chunk = (chunk_q == 0) ? 1 : chunk_q;
      blk   = dies * chunk;
      lim   = (total / blk) * blk;
      r     = id;
      // chiplet chunk remap below the last full block
      if (r < lim)
         r = ((r / dies) / chunk) * blk + (r % dies) * chunk + ((r / dies) % chunk);
      // grouped swizzle, last group clipped
      gh        = (group_q == 0) ? 1 : group_q;
      per_grp   = gh * cols_q;
      first     = (r / per_grp) * gh;
      left      = rows_q - first;
      rows_here = (gh < left) ? gh : left;
      loc       = r % per_grp;
      t.row = 16'(first + loc % rows_here);
      t.col = 16'(loc / rows_here);
      return t;
   endfunction

   assign pending_count = tile_queue.size();

   always @(posedge clock) begin
      tile_type want;
      int       errs;
      errs = 0;
      if (reset) begin
         rows_q  <= 16'd1;
         cols_q  <= 16'd1;
         group_q <= 8'd1;
         dies_q  <= 5'd1;
         chunk_q <= 8'd1;
         tile_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_TILE_ROWS:    rows_q  <= csr_data;
               CSR_TILE_COLS:    cols_q  <= csr_data;
               CSR_GROUP_HEIGHT: group_q <= csr_data[7:0];
               CSR_DIE_COUNT:    dies_q  <= csr_data[4:0];
               CSR_CHUNK_LENGTH: chunk_q <= csr_data[7:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            tile_queue.push_back(swizzle_tile(req_work_id));
         // compare result word with oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (tile_queue.size() == 0) begin
               $error("unexpected result word");
               errs++;
            end else begin
               want = tile_queue.pop_front();
               if (want.row !== rsp_tile_row) begin
                  $error("tile_row exp %0d got %0d", want.row, rsp_tile_row);
                  errs++;
               end
               if (want.col !== rsp_tile_col) begin
                  $error("tile_col exp %0d got %0d", want.col, rsp_tile_col);
                  errs++;
               end
               if (want.oor !== rsp_out_of_range) begin
                  $error("out_of_range exp %0d got %0d", want.oor, rsp_out_of_range);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end

endmodule

### tb/sv/chiplet_aware_tile_swizzle_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chiplet_aware_tile_swizzle_unit_tb
// Drives ids through the swizzle unit under several register settings and
// idle patterns; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module chiplet_aware_tile_swizzle_unit_tb;
   import ctsw_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [31:0]           req_work_id = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b1;
   logic [TILE_W-1:0]     rsp_tile_row, rsp_tile_col;
   logic                  rsp_out_of_range;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_TILE_ROWS;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   int                    fail_count, pending_count;
   int                    send_idle_pct = 0;
   int                    stall_pct = 0;
   int                    hold_cycles = 0;
   logic [15:0]           cur_rows = 16'd1, cur_cols = 16'd1;

   localparam int LATENCY = 158;

   always #1 clock = ~clock;

   chiplet_aware_tile_swizzle_unit #(.ID_BITS(32)) dut (.*);

   chiplet_aware_tile_swizzle_checker checker_i (.*);

   // receiver: random stalls, or a long counted hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else
         rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // send one word, waiting for acceptance; valid drops at the next idle
   task automatic send_id(logic [31:0] id);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_work_id <= id;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   // write enable is dropped by the caller after the last write
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      if (idx == CSR_TILE_ROWS) cur_rows = val;
      if (idx == CSR_TILE_COLS) cur_cols = val;
   endtask

   task automatic set_shape(logic [15:0] r, logic [15:0] c, logic [7:0] g,
                            logic [4:0] d, logic [7:0] k);
      drain_all();
      write_reg(CSR_TILE_ROWS, r);
      write_reg(CSR_TILE_COLS, c);
      write_reg(CSR_GROUP_HEIGHT, {8'd0, g});
      write_reg(CSR_DIE_COUNT, {11'd0, d});
      write_reg(CSR_CHUNK_LENGTH, {8'd0, k});
      csr_write <= 1'b0;
   endtask

   // mostly in range ids, some beyond and some wide
   function automatic logic [31:0] pick_id();
      int unsigned total;
      int unsigned sel;
      total = cur_rows * cur_cols;
      sel = $urandom_range(99);
      if (sel < 80 && total != 0) return $urandom_range(total - 1);
      if (sel < 90) return total + $urandom_range(3);
      return $urandom;
   endfunction

   initial begin
      int phase;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // directed: reset shape, extremes of the id
      send_id(32'd0);
      send_id(32'd1);
      send_id(32'hFFFF_FFFF);
      set_shape(16'd7, 16'd5, 8'd3, 5'd2, 8'd2);
      for (int i = 0; i < 12; i++) send_id(i * 3);
      send_id(32'd34);
      send_id(32'd35);
      // zero registers: treated as one, zero rows gives out of range
      set_shape(16'd6, 16'd4, 8'd0, 5'd0, 8'd0);
      send_id(32'd5);
      send_id(32'd23);
      set_shape(16'd0, 16'd9, 8'd1, 5'd1, 8'd1);
      send_id(32'd0);
      // die count above sixteen, largest sizes
      set_shape(16'hFFFF, 16'hFFFF, 8'd255, 5'd31, 8'd255);
      send_id(32'hFFFE_0000);
      send_id(32'h8000_0001);
      send_id(32'hFFFE_0001);
      // random phases over several shapes and idle patterns
      for (phase = 0; phase < 12; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 60; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 60; end
            default: begin send_idle_pct = 38; stall_pct = 38; end
         endcase
         if (phase == 11)
            set_shape(16'hFFFF, 16'hFFFF, 8'd255, 5'd16, 8'd255);
         else if (phase == 10)
            set_shape(16'd1, 16'd1, 8'd1, 5'd1, 8'd1);
         else
            set_shape(16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)),
                      8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                      8'($urandom_range(0, 255)));
         if (phase == 2) hold_cycles = 600;
         for (int i = 0; i < 150; i++) send_id(pick_id());
      end
      drain_all();
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
